// ===== sv/spq_pkg.sv =====
// Shared types and constants for the strict priority queue.
package spq_pkg;

	localparam int DEFAULT_DEPTH      = 16;
	localparam int DEFAULT_LEVELS     = 3;
	localparam int DEFAULT_DATA_WIDTH = 32;

	localparam int VALUE_W     = 32;
	localparam int PRI_W       = 2;
	localparam int TOTAL_W     = 5;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 40;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [TOTAL_W-1:0] LIMIT_RESET = TOTAL_W'(16);

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPRI = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_WRITE = 2'd1,
		MEM_READ  = 2'd2
	} mem_op_t;

	// result info that travels from the front to the back with each word
	typedef struct packed {
		mem_op_t              mem_op;
		status_t              status;
		logic                 empty;
		logic [TOTAL_W-1:0]   total;
	} res_info_t;

	localparam int INFO_W = $bits(res_info_t);

endpackage

// ===== sv/spq_front.sv =====
// Front end: classifies each word and keeps per-level ring pointers and counts.
module spq_front import spq_pkg::*; #(
	parameter int DEPTH      = DEFAULT_DEPTH,
	parameter int LEVELS     = DEFAULT_LEVELS,
	parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
	parameter int ADDR_W     = $clog2(LEVELS * DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  total_limit_we,
	input  logic [TOTAL_W-1:0]    total_limit_wdata,
	input  logic                  accept,
	input  op_t                   operation,
	input  logic [VALUE_W-1:0]    value,
	input  logic [PRI_W-1:0]      priority_req,
	output res_info_t             cmd_info,
	output logic [ADDR_W-1:0]     cmd_addr,
	output logic [DATA_WIDTH-1:0] cmd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LVL_W = $clog2(LEVELS);

	logic [TOTAL_W-1:0] total_limit_q;
	logic [TOTAL_W-1:0] held_q;
	logic [PTR_W-1:0]   head_q [LEVELS];
	logic [PTR_W-1:0]   tail_q [LEVELS];
	logic [CNT_W-1:0]   cnt_q  [LEVELS];

	logic               do_enq;
	logic               do_deq;
	logic [LVL_W-1:0]   enq_lv;
	logic [LVL_W-1:0]   deq_lv;
	logic               deq_found;
	logic               pri_ok;
	logic [TOTAL_W-1:0] held_next;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign pri_ok = (priority_req != '0) && (32'(priority_req) <= LEVELS);
	assign enq_lv = LVL_W'(priority_req - 1'b1);

	// highest non-empty level wins
	always_comb begin
		deq_lv    = '0;
		deq_found = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (cnt_q[i] != '0) begin
				deq_lv    = LVL_W'(i);
				deq_found = 1'b1;
			end
		end
	end

	always_comb begin
		do_enq    = 1'b0;
		do_deq    = 1'b0;
		held_next = held_q;
		cmd_info.mem_op = MEM_NONE;
		cmd_info.status = ST_DONE;
		cmd_addr  = '0;
		cmd_data  = DATA_WIDTH'(value);
		if (operation == OP_ENQ) begin
			priority if (held_q >= total_limit_q) begin
				cmd_info.status = ST_FULL;
			end else if (!pri_ok) begin
				cmd_info.status = ST_BADPRI;
			end else if (cnt_q[enq_lv] == CNT_W'(DEPTH)) begin
				cmd_info.status = ST_FULL;
			end else begin
				do_enq          = 1'b1;
				held_next       = held_q + 1'b1;
				cmd_info.mem_op = MEM_WRITE;
				cmd_addr        = ADDR_W'(enq_lv) * ADDR_W'(DEPTH) + ADDR_W'(tail_q[enq_lv]);
			end
		end else begin
			if (deq_found) begin
				do_deq          = 1'b1;
				held_next       = (held_q != '0) ? held_q - 1'b1 : held_q;
				cmd_info.mem_op = MEM_READ;
				cmd_addr        = ADDR_W'(deq_lv) * ADDR_W'(DEPTH) + ADDR_W'(head_q[deq_lv]);
			end else begin
				cmd_info.status = ST_EMPTY;
			end
		end
		cmd_info.total = held_next;
		cmd_info.empty = (held_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_limit_q <= LIMIT_RESET;
			held_q        <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (total_limit_we) begin
				total_limit_q <= total_limit_wdata;
			end
			if (accept) begin
				held_q <= held_next;
				if (do_enq) begin
					tail_q[enq_lv] <= ring_next(tail_q[enq_lv]);
					cnt_q[enq_lv]  <= cnt_q[enq_lv] + 1'b1;
				end
				if (do_deq) begin
					head_q[deq_lv] <= ring_next(head_q[deq_lv]);
					cnt_q[deq_lv]  <= cnt_q[deq_lv] - 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/spq_fifo.sv =====
// Small command queue between the front and the back.
module spq_fifo import spq_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/spq_back.sv =====
// Back end: level storage and the output register.
module spq_back import spq_pkg::*; #(
	parameter int DEPTH      = DEFAULT_DEPTH,
	parameter int LEVELS     = DEFAULT_LEVELS,
	parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
	parameter int ADDR_W     = $clog2(LEVELS * DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  res_info_t             q_info,
	input  logic [ADDR_W-1:0]     q_addr,
	input  logic [DATA_WIDTH-1:0] q_data,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata
);

	logic [DATA_WIDTH-1:0] mem_q [LEVELS * DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_s1;
	res_info_t             info_s1;
	logic                  valid_s1;
	logic [VALUE_W-1:0]    value_res;

	assign q_pop = q_valid && (!valid_s1 || m_tready);

	always_ff @(posedge clk) begin
		if (q_pop && q_info.mem_op == MEM_WRITE) begin
			mem_q[q_addr] <= q_data;
		end
		if (q_pop && q_info.mem_op == MEM_READ) begin
			rd_data_s1 <= mem_q[q_addr];
		end
		if (q_pop) begin
			info_s1 <= q_info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (q_pop) begin
			valid_s1 <= 1'b1;
		end else if (m_tready) begin
			valid_s1 <= 1'b0;
		end
	end

	// stored words are unsigned, zero extend or truncate to the field width
	assign value_res = (info_s1.mem_op == MEM_READ) ? VALUE_W'(rd_data_s1) : '0;
	assign m_tvalid  = valid_s1;
	assign m_tdata   = {info_s1.total, info_s1.empty, info_s1.status, value_res};

endmodule

// ===== sv/strict_priority_queue.sv =====
// Strict priority queue top level: front classifier, command queue, storage back end.
// Throughput: one word per cycle while the command queue is not full, for enqueue and dequeue alike.
// Path: an accepted word passes through the command queue, then its storage read goes
// into the output register.
// Reset: pointers, counts and valid flags clear at once and the limit returns to 16; storage is not cleared.
module strict_priority_queue import spq_pkg::*; #(
	parameter int DEPTH      = DEFAULT_DEPTH,
	parameter int LEVELS     = DEFAULT_LEVELS,
	parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 total_limit_we,
	input  logic [TOTAL_W-1:0]   total_limit_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // value[31:0], priority_req[33:32], zero pad
	input  logic                 s_tuser,   // operation
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // value_res[31:0], status[33:32],
	                                        // empty_res[34], total_count[39:35]
);

	localparam int ADDR_W = $clog2(LEVELS * DEPTH);
	localparam int CMD_W  = INFO_W + ADDR_W + DATA_WIDTH;

	logic                  accept;
	logic                  q_full;
	logic                  q_valid;
	logic                  q_pop;
	res_info_t             cmd_info;
	logic [ADDR_W-1:0]     cmd_addr;
	logic [DATA_WIDTH-1:0] cmd_data;
	logic [CMD_W-1:0]      q_out;
	res_info_t             q_info;
	logic [ADDR_W-1:0]     q_addr;
	logic [DATA_WIDTH-1:0] q_data;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	spq_front #(
		.DEPTH      (DEPTH),
		.LEVELS     (LEVELS),
		.DATA_WIDTH (DATA_WIDTH),
		.ADDR_W     (ADDR_W)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.total_limit_we    (total_limit_we),
		.total_limit_wdata (total_limit_wdata),
		.accept            (accept),
		.operation         (op_t'(s_tuser)),
		.value             (s_tdata[VALUE_W-1:0]),
		.priority_req      (s_tdata[VALUE_W+PRI_W-1:VALUE_W]),
		.cmd_info          (cmd_info),
		.cmd_addr          (cmd_addr),
		.cmd_data          (cmd_data)
	);

	spq_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data ({cmd_info, cmd_addr, cmd_data}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.not_empty (q_valid)
	);

	assign {q_info, q_addr, q_data} = q_out;

	spq_back #(
		.DEPTH      (DEPTH),
		.LEVELS     (LEVELS),
		.DATA_WIDTH (DATA_WIDTH),
		.ADDR_W     (ADDR_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_info   (q_info),
		.q_addr   (q_addr),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// refused operations never carry a value
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[VALUE_W+1:VALUE_W] != ST_DONE) |-> (m_tdata[VALUE_W-1:0] == '0))
		else $error("refused result carries a nonzero value");

	// an empty refusal means nothing is held
	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[VALUE_W+1:VALUE_W] == ST_EMPTY)
		|-> (m_tdata[M_TDATA_W-1:VALUE_W+3] == '0) && m_tdata[VALUE_W+2])
		else $error("empty refusal with values still held");

	// a word accepted into an empty pipe passes through the command queue and then shows up in the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !q_valid && !m_tvalid |=> ##1 m_tvalid)
		else $error("result missing two cycles after acceptance");

endmodule
